@@ hdl/mmrc_pkg.sv @@
// Shared types and constants of the missing mass region counter.
`timescale 1ns / 1ps
package mmrc_pkg;

   localparam int TRK_W   = 18;
   localparam int CDA_W   = 14;
   localparam int WIN_W   = 21;
   localparam int MASS_W  = 24;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 21;
   localparam int EN_W    = 41;
   localparam int SQ_STEPS = EN_W;
   localparam int SQ_CNT_W = $clog2(SQ_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_CDA_MIN   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN1_LOW  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN1_HIGH = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN2_LOW  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN2_HIGH = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BEAM_PX   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BEAM_PY   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BEAM_PZ   = 4'd7;

   localparam logic [35:0] P_MIN_SQ = 36'd225000000;
   localparam logic [35:0] P_MAX_SQ = 36'd2025000000;
   localparam logic [35:0] MK2_INT  = 36'd243716;
   localparam logic [35:0] MPI2_INT = 36'd19479;
   localparam logic [63:0] MK2_MICRO  = 64'd980329;
   localparam logic [63:0] MPI2_MICRO = 64'd784900;

   localparam logic [63:0] MK2_FRAC64 =
      (((MK2_MICRO << 24) / 64'd1000000) << 24)
      + ((((MK2_MICRO << 24) % 64'd1000000) << 24) + 64'd500000) / 64'd1000000;
   localparam logic [63:0] MPI2_FRAC64 =
      (((MPI2_MICRO << 24) / 64'd1000000) << 24)
      + ((((MPI2_MICRO << 24) % 64'd1000000) << 24) + 64'd500000) / 64'd1000000;
   localparam logic [47:0] MK2_FRAC  = MK2_FRAC64[47:0];
   localparam logic [47:0] MPI2_FRAC = MPI2_FRAC64[47:0];

   typedef enum logic [3:0] {
      OP_NONE, OP_MUL, OP_ACC, OP_SAVE_TP, OP_SAVE_BP, OP_SAVE_DP,
      OP_SQ_INIT_K, OP_SQ_INIT_P, OP_SQ_STEP, OP_SQ_SAVE_K, OP_SQ_SAVE_P,
      OP_DIFF, OP_ROUND, OP_FINAL
   } dp_op_type;

   typedef enum logic [3:0] {
      SEL_TX, SEL_TY, SEL_TZ, SEL_BX, SEL_BY, SEL_BZ,
      SEL_DX, SEL_DY, SEL_DZ, SEL_HH, SEL_HL, SEL_LL
   } mul_sel_type;

   typedef struct packed {
      dp_op_type   op;
      mul_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic ok;
   } dp_status_type;

   typedef struct packed {
      logic                     accepted;
      logic signed [MASS_W-1:0] miss_mass_sq;
      logic                     in_win1;
      logic                     in_win2;
      logic [31:0]              count_win1;
      logic [31:0]              count_win2;
   } rsp_word_type;

endpackage

@@ hdl/mmrc_if.sv @@
// Channel interfaces of the missing mass region counter.
`timescale 1ns / 1ps
interface mmrc_req_if import mmrc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [2:0]       charge;
   logic [CDA_W-1:0]        cda;
   logic signed [TRK_W-1:0] trk_px;
   logic signed [TRK_W-1:0] trk_py;
   logic signed [TRK_W-1:0] trk_pz;
   modport source (output valid, charge, cda, trk_px, trk_py, trk_pz, input ready);
   modport sink (input valid, charge, cda, trk_px, trk_py, trk_pz, output ready);
endinterface

interface mmrc_rsp_if import mmrc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic signed [MASS_W-1:0] miss_mass_sq;
   logic                     in_win1;
   logic                     in_win2;
   logic [31:0]              count_win1;
   logic [31:0]              count_win2;
   modport source (output valid, accepted, miss_mass_sq, in_win1, in_win2,
                   count_win1, count_win2, input ready);
   modport sink (input valid, accepted, miss_mass_sq, in_win1, in_win2,
                 count_win1, count_win2, output ready);
endinterface

interface mmrc_csr_if import mmrc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/missing_mass_region_counter.sv @@
// Missing mass region counter: vertex selection, squared missing mass and window counts.
//
// req_port takes one track vertex word (charge, cda, momentum); rsp_port returns one
// result word per vertex: pass flag, squared missing mass, window flags and both counts.
// csr_port writes the cut, window and beam registers; it is always ready and must only
// be used while no vertex is in flight.
// A passing vertex's time from acceptance to result is set by the shared square root
// unit, which resolves one bit of each 41-bit energy per cycle (two energies), plus
// three groups of squares and the energy difference square on one shared multiplier;
// a rejected vertex stops after the first group of squares.
// One vertex is in work at a time; the next is taken as soon as the previous result
// sits in the output register, even if that word has not been taken yet.
// A stalled receiver holds the result word; the block finishes its current vertex and
// waits before loading the output register again.
// Reset restores the register defaults, clears both counters and leaves the block
// ready with no result pending.
`timescale 1ns / 1ps
module missing_mass_region_counter import mmrc_pkg::*; #(
   parameter int COUNT_WIDTH = 32
) (
   input logic         clock,
   input logic         reset,
   mmrc_req_if.sink    req_port,
   mmrc_rsp_if.source  rsp_port,
   mmrc_csr_if.sink    csr_port
);

   dp_cmd_type    cmd;
   dp_status_type status;
   rsp_word_type  rsp_word;
   logic          load;

   assign load          = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;

   mmrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mmrc_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .charge    (req_port.charge),
      .cda       (req_port.cda),
      .trk_px    (req_port.trk_px),
      .trk_py    (req_port.trk_py),
      .trk_pz    (req_port.trk_pz),
      .csr_write (csr_port.valid),
      .csr_index (csr_port.index),
      .csr_data  (csr_port.data),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_word)
   );

   assign rsp_port.accepted     = rsp_word.accepted;
   assign rsp_port.miss_mass_sq = rsp_word.miss_mass_sq;
   assign rsp_port.in_win1      = rsp_word.in_win1;
   assign rsp_port.in_win2      = rsp_word.in_win2;
   assign rsp_port.count_win1   = rsp_word.count_win1;
   assign rsp_port.count_win2   = rsp_word.count_win2;

`ifndef SYNTHESIS
   a_idle_no_cmd: assert property (@(posedge clock) disable iff (reset)
      req_port.ready |-> cmd.op == OP_NONE)
      else $error("datapath command issued while taking a new word");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FINAL |-> (!rsp_port.valid || rsp_port.ready))
      else $error("result register loaded over a pending word");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && !rsp_port.accepted) |->
      (rsp_port.miss_mass_sq == '0 && !rsp_port.in_win1 && !rsp_port.in_win2))
      else $error("rejected vertex reports a mass or window hit");
`endif

endmodule

@@ hdl/mmrc_ctrl.sv @@
// Sequencer that steps the datapath through one vertex.
`timescale 1ns / 1ps
module mmrc_ctrl import mmrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_ACC, ST_SAVE, ST_CHECK, ST_SQ_INIT, ST_SQ_STEP,
      ST_SQ_SAVE, ST_DIFF, ST_ROUND, ST_FINAL
   } state_type;

   typedef enum logic [1:0] {GRP_TP, GRP_BP, GRP_DP, GRP_AD} group_type;

   state_type             state_ff;
   group_type             group_ff;
   logic [1:0]            idx_ff;
   logic [SQ_CNT_W-1:0]   step_ff;
   logic                  sq_p_ff;
   logic                  req_ready_ff;
   logic                  rsp_valid_ff;
   logic                  fin_go;
   logic [1:0]            idx_last;

   function automatic mul_sel_type sel_of(group_type g, logic [1:0] i);
      mul_sel_type s;
      s = SEL_TX;
      unique case (g)
         GRP_TP: s = (i == 2'd0) ? SEL_TX : (i == 2'd1) ? SEL_TY : SEL_TZ;
         GRP_BP: s = (i == 2'd0) ? SEL_BX : (i == 2'd1) ? SEL_BY : SEL_BZ;
         GRP_DP: s = (i == 2'd0) ? SEL_DX : (i == 2'd1) ? SEL_DY : SEL_DZ;
         GRP_AD: s = (i == 2'd0) ? SEL_HH : (i == 2'd3) ? SEL_LL : SEL_HL;
      endcase
      return s;
   endfunction

   assign fin_go    = !rsp_valid_ff || rsp_ready;
   assign idx_last  = (group_ff == GRP_AD) ? 2'd3 : 2'd2;
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.op  = OP_NONE;
      cmd.sel = sel_of(group_ff, idx_ff);
      unique case (state_ff)
         ST_IDLE:    cmd.op = OP_NONE;
         ST_MUL:     cmd.op = OP_MUL;
         ST_ACC:     cmd.op = OP_ACC;
         ST_SAVE: begin
            unique case (group_ff)
               GRP_TP: cmd.op = OP_SAVE_TP;
               GRP_BP: cmd.op = OP_SAVE_BP;
               GRP_DP: cmd.op = OP_SAVE_DP;
               GRP_AD: cmd.op = OP_NONE;
            endcase
         end
         ST_CHECK:   cmd.op = OP_NONE;
         ST_SQ_INIT: cmd.op = sq_p_ff ? OP_SQ_INIT_P : OP_SQ_INIT_K;
         ST_SQ_STEP: cmd.op = OP_SQ_STEP;
         ST_SQ_SAVE: cmd.op = sq_p_ff ? OP_SQ_SAVE_P : OP_SQ_SAVE_K;
         ST_DIFF:    cmd.op = OP_DIFF;
         ST_ROUND:   cmd.op = OP_ROUND;
         ST_FINAL:   cmd.op = fin_go ? OP_FINAL : OP_NONE;
         default:    cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         group_ff     <= GRP_TP;
         idx_ff       <= 2'd0;
         step_ff      <= '0;
         sq_p_ff      <= 1'b0;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !(state_ff == ST_FINAL && fin_go)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  req_ready_ff <= 1'b0;
                  group_ff     <= GRP_TP;
                  idx_ff       <= 2'd0;
                  state_ff     <= ST_MUL;
               end
            end
            ST_MUL: state_ff <= ST_ACC;
            ST_ACC: begin
               if (idx_ff == idx_last) begin
                  idx_ff   <= 2'd0;
                  state_ff <= (group_ff == GRP_AD) ? ST_ROUND : ST_SAVE;
               end else begin
                  idx_ff   <= idx_ff + 2'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_SAVE: begin
               unique case (group_ff)
                  GRP_TP: state_ff <= ST_CHECK;
                  GRP_BP: begin
                     group_ff <= GRP_DP;
                     state_ff <= ST_MUL;
                  end
                  GRP_DP: begin
                     sq_p_ff  <= 1'b0;
                     state_ff <= ST_SQ_INIT;
                  end
                  GRP_AD: state_ff <= ST_ROUND;
               endcase
            end
            ST_CHECK: begin
               if (status.ok) begin
                  group_ff <= GRP_BP;
                  state_ff <= ST_MUL;
               end else begin
                  state_ff <= ST_FINAL;
               end
            end
            ST_SQ_INIT: begin
               step_ff  <= '0;
               state_ff <= ST_SQ_STEP;
            end
            ST_SQ_STEP: begin
               if (step_ff == SQ_CNT_W'(SQ_STEPS - 1)) begin
                  state_ff <= ST_SQ_SAVE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_SQ_SAVE: begin
               if (!sq_p_ff) begin
                  sq_p_ff  <= 1'b1;
                  state_ff <= ST_SQ_INIT;
               end else begin
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: begin
               group_ff <= GRP_AD;
               idx_ff   <= 2'd0;
               state_ff <= ST_MUL;
            end
            ST_ROUND: state_ff <= ST_FINAL;
            ST_FINAL: begin
               if (fin_go) begin
                  rsp_valid_ff <= 1'b1;
                  req_ready_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ hdl/mmrc_datapath.sv @@
// Registers, shared multiplier, square root unit and counters.
`timescale 1ns / 1ps
module mmrc_datapath import mmrc_pkg::*; #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic signed [2:0]       charge,
   input  logic [CDA_W-1:0]        cda,
   input  logic signed [TRK_W-1:0] trk_px,
   input  logic signed [TRK_W-1:0] trk_py,
   input  logic signed [TRK_W-1:0] trk_pz,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   output rsp_word_type            rsp_word
);

   logic [CDA_W-1:0]         cda_min_ff;
   logic signed [WIN_W-1:0]  w1l_ff, w1h_ff, w2l_ff, w2h_ff;
   logic signed [TRK_W-1:0]  bx_ff, by_ff, bz_ff;

   logic signed [2:0]        charge_ff;
   logic [CDA_W-1:0]         cda_ff;
   logic signed [TRK_W-1:0]  tx_ff, ty_ff, tz_ff;

   mul_sel_type              sel_ff;
   logic signed [21:0]       opa, opb;
   logic signed [43:0]       prod_ff;
   logic [83:0]              acc_ff, acc_in, addend;
   logic signed [18:0]       dx, dy, dz;

   logic [35:0]              tp2_ff, bp2_ff;
   logic [37:0]              dp2_ff;
   logic                     ok_ff;

   logic [35:0]              sq_s;
   logic [81:0]              rad_ff;
   logic [42:0]              rem_ff;
   logic [EN_W-1:0]          root_ff;
   logic                     sat_ff;
   logic [44:0]              rem_t, trial;
   logic [EN_W-1:0]          ek_ff, ep_ff, ad_ff, en_sat;

   logic [83:0]              rnd;
   logic [35:0]              q_ff;
   logic signed [41:0]       mm;
   logic signed [MASS_W-1:0] mm_sat;
   logic                     h1, h2;

   logic [COUNT_WIDTH-1:0]   c1_ff, c2_ff, c1_in, c2_in;
   rsp_word_type             rsp_ff;

   assign dx = 19'(bx_ff) - 19'(tx_ff);
   assign dy = 19'(by_ff) - 19'(ty_ff);
   assign dz = 19'(bz_ff) - 19'(tz_ff);

   always_comb begin
      opa = '0;
      opb = '0;
      unique case (cmd.sel)
         SEL_TX: begin opa = 22'(tx_ff); opb = 22'(tx_ff); end
         SEL_TY: begin opa = 22'(ty_ff); opb = 22'(ty_ff); end
         SEL_TZ: begin opa = 22'(tz_ff); opb = 22'(tz_ff); end
         SEL_BX: begin opa = 22'(bx_ff); opb = 22'(bx_ff); end
         SEL_BY: begin opa = 22'(by_ff); opb = 22'(by_ff); end
         SEL_BZ: begin opa = 22'(bz_ff); opb = 22'(bz_ff); end
         SEL_DX: begin opa = 22'(dx); opb = 22'(dx); end
         SEL_DY: begin opa = 22'(dy); opb = 22'(dy); end
         SEL_DZ: begin opa = 22'(dz); opb = 22'(dz); end
         SEL_HH: begin
            opa = $signed({2'b00, ad_ff[40:21]});
            opb = $signed({2'b00, ad_ff[40:21]});
         end
         SEL_HL: begin
            opa = $signed({2'b00, ad_ff[40:21]});
            opb = $signed({1'b0, ad_ff[20:0]});
         end
         SEL_LL: begin
            opa = $signed({1'b0, ad_ff[20:0]});
            opb = $signed({1'b0, ad_ff[20:0]});
         end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   always_comb begin
      addend = {40'd0, prod_ff};
      unique case (sel_ff)
         SEL_HH:  addend = {40'd0, prod_ff} << 42;
         SEL_HL:  addend = {40'd0, prod_ff} << 21;
         default: addend = {40'd0, prod_ff};
      endcase
      if (sel_ff == SEL_TX || sel_ff == SEL_BX || sel_ff == SEL_DX || sel_ff == SEL_HH) begin
         acc_in = addend;
      end else begin
         acc_in = acc_ff + addend;
      end
   end

   assign sq_s   = (cmd.op == OP_SQ_INIT_P) ? tp2_ff + MPI2_INT : bp2_ff + MK2_INT;
   assign rem_t  = {rem_ff[42:0], rad_ff[81:80]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign en_sat = sat_ff ? '1 : root_ff;

   assign rnd = acc_ff + (84'd1 << 47);
   assign mm  = $signed({6'd0, q_ff}) - $signed({4'd0, dp2_ff});

   always_comb begin
      if (mm > 42'sd8388607) begin
         mm_sat = 24'sd8388607;
      end else if (mm < -42'sd8388608) begin
         mm_sat = -24'sd8388608;
      end else begin
         mm_sat = mm[MASS_W-1:0];
      end
      h1 = ok_ff && (mm_sat > w1l_ff) && (mm_sat < w1h_ff);
      h2 = ok_ff && (mm_sat > w2l_ff) && (mm_sat < w2h_ff);
      c1_in = h1 ? c1_ff + 1'b1 : c1_ff;
      c2_in = h2 ? c2_ff + 1'b1 : c2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cda_min_ff <= 14'd256;
         w1l_ff     <= 21'sd0;
         w1h_ff     <= 21'sd10000;
         w2l_ff     <= 21'sd26000;
         w2h_ff     <= 21'sd68000;
         bx_ff      <= 18'sd0;
         by_ff      <= 18'sd0;
         bz_ff      <= 18'sd75000;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CDA_MIN:   cda_min_ff <= csr_data[CDA_W-1:0];
            CSR_WIN1_LOW:  w1l_ff     <= $signed(csr_data);
            CSR_WIN1_HIGH: w1h_ff     <= $signed(csr_data);
            CSR_WIN2_LOW:  w2l_ff     <= $signed(csr_data);
            CSR_WIN2_HIGH: w2h_ff     <= $signed(csr_data);
            CSR_BEAM_PX:   bx_ff      <= $signed(csr_data[TRK_W-1:0]);
            CSR_BEAM_PY:   by_ff      <= $signed(csr_data[TRK_W-1:0]);
            CSR_BEAM_PZ:   bz_ff      <= $signed(csr_data[TRK_W-1:0]);
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         ok_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_SAVE_TP) begin
            ok_ff <= (charge_ff == 3'sd1) && (cda_ff >= cda_min_ff)
                     && (acc_ff[35:0] >= P_MIN_SQ) && (acc_ff[35:0] <= P_MAX_SQ);
         end
         if (cmd.op == OP_FINAL) begin
            c1_ff <= c1_in;
            c2_ff <= c2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         charge_ff <= charge;
         cda_ff    <= cda;
         tx_ff     <= trk_px;
         ty_ff     <= trk_py;
         tz_ff     <= trk_pz;
      end
      unique case (cmd.op)
         OP_MUL: begin
            prod_ff <= opa * opb;
            sel_ff  <= cmd.sel;
         end
         OP_ACC:     acc_ff <= acc_in;
         OP_SAVE_TP: tp2_ff <= acc_ff[35:0];
         OP_SAVE_BP: bp2_ff <= acc_ff[35:0];
         OP_SAVE_DP: dp2_ff <= acc_ff[37:0];
         OP_SQ_INIT_K, OP_SQ_INIT_P: begin
            sat_ff  <= |sq_s[35:34];
            rad_ff  <= {sq_s[33:0], (cmd.op == OP_SQ_INIT_P) ? MPI2_FRAC : MK2_FRAC};
            rem_ff  <= '0;
            root_ff <= '0;
         end
         OP_SQ_STEP: begin
            rad_ff <= rad_ff << 2;
            if (rem_t >= trial) begin
               rem_ff  <= 43'(rem_t - trial);
               root_ff <= {root_ff[EN_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_t[42:0];
               root_ff <= {root_ff[EN_W-2:0], 1'b0};
            end
         end
         OP_SQ_SAVE_K: ek_ff <= en_sat;
         OP_SQ_SAVE_P: ep_ff <= en_sat;
         OP_DIFF:      ad_ff <= (ek_ff >= ep_ff) ? ek_ff - ep_ff : ep_ff - ek_ff;
         OP_ROUND:     q_ff  <= rnd[83:48];
         OP_FINAL: begin
            rsp_ff.accepted     <= ok_ff;
            rsp_ff.miss_mass_sq <= ok_ff ? mm_sat : '0;
            rsp_ff.in_win1      <= h1;
            rsp_ff.in_win2      <= h2;
            rsp_ff.count_win1   <= 32'(c1_in);
            rsp_ff.count_win2   <= 32'(c2_in);
         end
         default: ;
      endcase
   end

   assign status.ok = ok_ff;
   assign rsp_word  = rsp_ff;

endmodule

@@ test/tb_top.sv @@
// Testbench for the missing mass region counter: directed and random vertices, checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
   import mmrc_pkg::*;

   localparam longint MAX_CYCLES = 4000000;
   localparam logic [63:0] KAON_MICRO = 64'd980329;
   localparam logic [63:0] PION_MICRO = 64'd784900;
   localparam logic [63:0] KAON_FRAC =
      (((KAON_MICRO << 24) / 64'd1000000) << 24)
      + ((((KAON_MICRO << 24) % 64'd1000000) << 24) + 64'd500000) / 64'd1000000;
   localparam logic [63:0] PION_FRAC =
      (((PION_MICRO << 24) / 64'd1000000) << 24)
      + ((((PION_MICRO << 24) % 64'd1000000) << 24) + 64'd500000) / 64'd1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   longint cycle_count = 0;
   int fail_count = 0;
   int sent_count = 0;
   int got_count = 0;
   int pass_count = 0;
   bit rsp_hold = 1'b0;

   logic [13:0] cut_cda;
   logic signed [20:0] w1_lo, w1_hi, w2_lo, w2_hi;
   logic signed [17:0] bm_x, bm_y, bm_z;
   logic [31:0] hits1, hits2;

   mmrc_req_if req_bus();
   mmrc_rsp_if rsp_bus();
   mmrc_csr_if csr_bus();

   missing_mass_region_counter uut (
      .clock(clock), .reset(reset),
      .req_port(req_bus.sink), .rsp_port(rsp_bus.source), .csr_port(csr_bus.sink)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("timeout at %0t", $time);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [40:0] energy_q24(logic [63:0] p2, logic [63:0] m2i,
                                              logic [63:0] m2f);
      logic [63:0] s;
      logic [127:0] rad;
      logic [40:0] res;
      logic [81:0] cand;
      s = p2 + m2i;
      if ((s >> 16) >= 64'd262144) return {41{1'b1}};
      rad = {s, 48'd0} + {80'd0, m2f[47:0]};
      res = '0;
      for (int b = 40; b >= 0; b--) begin
         cand = {41'd0, res | (41'd1 << b)};
         if (cand * cand <= rad) res = res | (41'd1 << b);
      end
      return res;
   endfunction

   function automatic rsp_word_type vertex_result(logic signed [2:0] chg, logic [13:0] cda,
                                                  logic signed [17:0] px, logic signed [17:0] py,
                                                  logic signed [17:0] pz);
      rsp_word_type r;
      longint tp2, bp2, dp2, mm, dx, dy, dz;
      logic [40:0] ek, ep, ad;
      logic [81:0] sq;
      r = '0;
      tp2 = longint'(px) * px + longint'(py) * py + longint'(pz) * pz;
      r.accepted = chg == 3'sd1 && cda >= cut_cda && tp2 >= 225000000 && tp2 <= 2025000000;
      if (r.accepted) begin
         bp2 = longint'(bm_x) * bm_x + longint'(bm_y) * bm_y + longint'(bm_z) * bm_z;
         ek = energy_q24(bp2, 64'd243716, KAON_FRAC);
         ep = energy_q24(tp2, 64'd19479, PION_FRAC);
         ad = ek >= ep ? ek - ep : ep - ek;
         sq = {41'd0, ad} * {41'd0, ad} + (82'd1 << 47);
         dx = longint'(bm_x) - px;
         dy = longint'(bm_y) - py;
         dz = longint'(bm_z) - pz;
         dp2 = dx * dx + dy * dy + dz * dz;
         mm = longint'(sq[81:48]) - dp2;
         if (mm > 8388607) mm = 8388607;
         if (mm < -8388608) mm = -8388608;
         r.miss_mass_sq = mm[23:0];
         r.in_win1 = mm > longint'(w1_lo) && mm < longint'(w1_hi);
         r.in_win2 = mm > longint'(w2_lo) && mm < longint'(w2_hi);
         if (r.in_win1) hits1 = hits1 + 1;
         if (r.in_win2) hits2 = hits2 + 1;
      end
      r.count_win1 = hits1;
      r.count_win2 = hits2;
      return r;
   endfunction

   class mass_scoreboard;
      rsp_word_type pending[$];

      function void note_vertex(logic signed [2:0] chg, logic [13:0] cda,
                                logic signed [17:0] px, logic signed [17:0] py,
                                logic signed [17:0] pz);
         pending.push_back(vertex_result(chg, cda, px, py, pz));
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type exp_w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            fail_count++;
            return;
         end
         exp_w = pending.pop_front();
         if (got.accepted !== exp_w.accepted || got.miss_mass_sq !== exp_w.miss_mass_sq ||
             got.in_win1 !== exp_w.in_win1 || got.in_win2 !== exp_w.in_win2 ||
             got.count_win1 !== exp_w.count_win1 || got.count_win2 !== exp_w.count_win2) begin
            $display("%0t: mismatch exp acc=%b mm=%0d w=%b%b c=%0d/%0d got acc=%b mm=%0d w=%b%b c=%0d/%0d",
               $time, exp_w.accepted, exp_w.miss_mass_sq, exp_w.in_win1, exp_w.in_win2,
               exp_w.count_win1, exp_w.count_win2, got.accepted, got.miss_mass_sq,
               got.in_win1, got.in_win2, got.count_win1, got.count_win2);
            fail_count++;
         end
      endfunction
   endclass

   mass_scoreboard board = new();

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.charge <= '0;
      req_bus.cda <= '0;
      req_bus.trk_px <= '0;
      req_bus.trk_py <= '0;
      req_bus.trk_pz <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      rsp_bus.ready <= 1'b0;
   end

   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         w.accepted = rsp_bus.accepted;
         w.miss_mass_sq = rsp_bus.miss_mass_sq;
         w.in_win1 = rsp_bus.in_win1;
         w.in_win2 = rsp_bus.in_win2;
         w.count_win1 = rsp_bus.count_win1;
         w.count_win2 = rsp_bus.count_win2;
         board.check_word(w);
         got_count++;
      end
   end

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (3000) @(posedge clock);
            rsp_hold = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [20:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_CDA_MIN: cut_cda = val[13:0];
         CSR_WIN1_LOW: w1_lo = val;
         CSR_WIN1_HIGH: w1_hi = val;
         CSR_WIN2_LOW: w2_lo = val;
         CSR_WIN2_HIGH: w2_hi = val;
         CSR_BEAM_PX: bm_x = val[17:0];
         CSR_BEAM_PY: bm_y = val[17:0];
         CSR_BEAM_PZ: bm_z = val[17:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_vertex(logic signed [2:0] chg, logic [13:0] cda,
                              logic signed [17:0] px, logic signed [17:0] py,
                              logic signed [17:0] pz, bit no_gap);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.charge <= chg;
      req_bus.cda <= cda;
      req_bus.trk_px <= px;
      req_bus.trk_py <= py;
      req_bus.trk_pz <= pz;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_vertex(chg, cda, px, py, pz);
      sent_count++;
   endtask

   task automatic drain_all();
      req_bus.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic random_vertex(bit no_gap);
      logic signed [17:0] px, py, pz;
      logic signed [2:0] chg;
      logic [13:0] cda;
      int mode;
      mode = $urandom_range(0, 9);
      chg = (mode < 8) ? 3'sd1 : 3'($urandom);
      cda = (mode < 7) ? 14'($urandom_range(cut_cda, 16383)) : 14'($urandom);
      if (mode < 8) begin
         px = 18'($signed($urandom_range(0, 4000)) - 2000);
         py = 18'($signed($urandom_range(0, 4000)) - 2000);
         pz = 18'($urandom_range(15000, 44000));
         if ($urandom_range(0, 5) == 0) pz = -pz;
      end else begin
         px = 18'($urandom);
         py = 18'($urandom);
         pz = 18'($urandom);
      end
      send_vertex(chg, cda, px, py, pz, no_gap);
   endtask

   task automatic random_setting();
      write_reg(CSR_CDA_MIN, 21'($urandom_range(0, 600)));
      write_reg(CSR_WIN1_LOW, 21'($signed($urandom_range(0, 60000)) - 30000));
      write_reg(CSR_WIN1_HIGH, 21'($urandom_range(0, 60000)));
      write_reg(CSR_WIN2_LOW, 21'($signed($urandom_range(0, 60000)) - 10000));
      write_reg(CSR_WIN2_HIGH, 21'($urandom_range(20000, 300000)));
      write_reg(CSR_BEAM_PX, 21'($signed($urandom_range(0, 400)) - 200));
      write_reg(CSR_BEAM_PY, 21'($signed($urandom_range(0, 400)) - 200));
      write_reg(CSR_BEAM_PZ, 21'($urandom_range(70000, 80000)));
   endtask

   initial begin
      cut_cda = 14'd256;
      w1_lo = 0; w1_hi = 10000; w2_lo = 26000; w2_hi = 68000;
      bm_x = 0; bm_y = 0; bm_z = 18'sd75000;
      hits1 = 0; hits2 = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults, then cut edges and field extremes
      send_vertex(3'sd1, 14'd256, 18'sd0, 18'sd0, 18'sd15000, 1'b0);
      send_vertex(3'sd1, 14'd255, 18'sd0, 18'sd0, 18'sd15000, 1'b0);
      send_vertex(3'sd1, 14'd16383, 18'sd0, 18'sd0, 18'sd45000, 1'b0);
      send_vertex(3'sd1, 14'd400, 18'sd0, 18'sd0, 18'sd45001, 1'b0);
      send_vertex(3'sd1, 14'd400, 18'sd0, 18'sd0, 18'sd14999, 1'b0);
      send_vertex(3'sd0, 14'd400, 18'sd0, 18'sd0, 18'sd30000, 1'b0);
      send_vertex(-3'sd4, 14'd400, 18'sd0, 18'sd0, 18'sd30000, 1'b0);
      send_vertex(3'sd3, 14'd400, 18'sd0, 18'sd0, 18'sd30000, 1'b0);
      send_vertex(-3'sd1, 14'd0, -18'sd131072, -18'sd131072, -18'sd131072, 1'b0);
      send_vertex(3'sd1, 14'd16383, 18'sd131071, 18'sd131071, 18'sd131071, 1'b0);
      send_vertex(3'sd1, 14'd300, 18'sd0, 18'sd0, -18'sd30000, 1'b0);
      send_vertex(3'sd1, 14'd300, 18'sd1000, -18'sd1000, 18'sd40000, 1'b0);
      drain_all();

      // extreme beam: energy and mass saturation, an inverted first window
      write_reg(CSR_CDA_MIN, 14'd0);
      write_reg(CSR_WIN1_LOW, 21'h0FFFFF);
      write_reg(CSR_WIN1_HIGH, 21'h100000);
      write_reg(CSR_WIN2_LOW, 21'h100000);
      write_reg(CSR_WIN2_HIGH, 21'h0FFFFF);
      write_reg(CSR_BEAM_PX, 21'h1FFFF);
      write_reg(CSR_BEAM_PY, 21'h1FFFF);
      write_reg(CSR_BEAM_PZ, 21'h1FFFF);
      write_reg(4'd12, 21'h1FFFFF);
      send_vertex(3'sd1, 14'd0, 18'sd0, 18'sd0, 18'sd20000, 1'b0);
      send_vertex(3'sd1, 14'd0, 18'sd0, 18'sd0, -18'sd45000, 1'b0);
      drain_all();
      write_reg(CSR_BEAM_PX, 21'h20000);
      write_reg(CSR_BEAM_PY, 21'h20000);
      write_reg(CSR_BEAM_PZ, 21'h20000);
      write_reg(CSR_CDA_MIN, 14'h3FFF);
      write_reg(CSR_WIN1_LOW, 21'h100000);
      write_reg(CSR_WIN1_HIGH, 21'h0FFFFF);
      send_vertex(3'sd1, 14'h3FFF, 18'sd0, 18'sd0, 18'sd20000, 1'b0);
      send_vertex(3'sd1, 14'h3FFF, 18'sd0, 18'sd30000, 18'sd0, 1'b0);
      send_vertex(3'sd1, 14'h3FFE, 18'sd0, 18'sd30000, 18'sd0, 1'b0);
      drain_all();

      for (int ph = 0; ph < 7; ph++) begin
         random_setting();
         if (ph == 2) rsp_hold = 1'b1;
         for (int i = 0; i < 200; i++) begin
            random_vertex(ph == 2 && i < 20);
            if (i == 100) drain_all();
         end
         drain_all();
      end

      $display("%0d vertices sent, %0d results checked, %0d passed the cuts", sent_count,
               got_count, pass_count);
      $display("covered cut edges, energy and mass saturation, inverted windows and stalls");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready && rsp_bus.accepted) pass_count++;
   end
endmodule

@@ sim.f @@
hdl/mmrc_pkg.sv
hdl/mmrc_if.sv
hdl/mmrc_ctrl.sv
hdl/mmrc_datapath.sv
hdl/missing_mass_region_counter.sv
test/tb_top.sv
